### src/u8sv_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
package u8sv_pkg;

  // Longest message the byte counters track before they saturate
  localparam int unsigned MaxMessageBytes = 65535;
  localparam int unsigned CountW = $clog2(MaxMessageBytes + 1);

  // Classifier queue depth between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // Byte masks and patterns used by the classifier
  localparam logic [7:0] MaskTop2  = 8'hC0;
  localparam logic [7:0] MaskTop3  = 8'hE0;
  localparam logic [7:0] MaskTop4  = 8'hF0;
  localparam logic [7:0] MaskTop5  = 8'hF8;
  localparam logic [7:0] PatCont   = 8'h80;
  localparam logic [7:0] PatLead2  = 8'hC0;
  localparam logic [7:0] PatLead3  = 8'hE0;
  localparam logic [7:0] PatLead4  = 8'hF0;
  localparam logic [7:0] PatSurr   = 8'hA0;
  localparam logic [7:0] ByteC0    = 8'hC0;
  localparam logic [7:0] ByteC1    = 8'hC1;
  localparam logic [7:0] ByteE0    = 8'hE0;
  localparam logic [7:0] ByteED    = 8'hED;
  localparam logic [7:0] ByteF0    = 8'hF0;
  localparam logic [7:0] ByteF4    = 8'hF4;

  // Limit on the first continuation byte after certain leads
  typedef enum logic [1:0] {
    RULE_NONE = 2'd0,
    RULE_E0   = 2'd1,
    RULE_ED   = 2'd2,
    RULE_F0   = 2'd3
  } rule_e;

  // Byte class as seen with no sequence in progress
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } kind_e;

  // Classified byte passed from front to back
  typedef struct packed {
    kind_e kind;
    rule_e rule;
    logic  is_cont;
    logic  viol_e0;
    logic  viol_ed;
    logic  viol_f0;
    logic  last;
  } byte_class_t;

endpackage

### src/u8sv_front.sv
// Front end: accepts bytes and classifies each one for the parser.
module u8sv_front import u8sv_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        cls_valid_o,
  input  logic        cls_ready_i,
  output byte_class_t cls_o
);

  logic [7:0] b;

  assign b           = data_byte_i;
  assign in_ready_o  = cls_ready_i;
  assign cls_valid_o = in_valid_i;

  // Classify the byte and flag second-byte range violations
  always_comb begin
    cls_o         = '0;
    cls_o.kind    = KIND_BAD;
    cls_o.rule    = RULE_NONE;
    cls_o.last    = last_byte_i;
    cls_o.is_cont = ((b & MaskTop2) == PatCont);
    cls_o.viol_e0 = ((b & MaskTop3) == PatCont);
    cls_o.viol_ed = ((b & MaskTop3) == PatSurr);
    cls_o.viol_f0 = ((b & MaskTop4) == PatCont);
    if (!b[7]) begin
      cls_o.kind = KIND_ASCII;
    end else if ((b & MaskTop2) == PatCont) begin
      cls_o.kind = KIND_CONT;
    end else if ((b & MaskTop3) == PatLead2) begin
      cls_o.kind = (b == ByteC0 || b == ByteC1) ? KIND_BAD : KIND_LEAD2;
    end else if ((b & MaskTop4) == PatLead3) begin
      cls_o.kind = KIND_LEAD3;
      if (b == ByteE0) begin
        cls_o.rule = RULE_E0;
      end else if (b == ByteED) begin
        cls_o.rule = RULE_ED;
      end
    end else if ((b & MaskTop5) == PatLead4 && b <= ByteF4) begin
      cls_o.kind = KIND_LEAD4;
      if (b == ByteF0) begin
        cls_o.rule = RULE_F0;
      end
    end
  end

endmodule

### src/u8sv_queue.sv
// Short queue of classified bytes between front and back.
module u8sv_queue import u8sv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  byte_class_t push_data_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output byte_class_t pop_data_o
);

  byte_class_t            entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry on push
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/u8sv_back.sv
// Back end: tracks sequence state and counts, and registers the verdict.
module u8sv_back import u8sv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cls_valid_i,
  output logic        cls_ready_o,
  input  byte_class_t cls_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_valid_o
);

  logic [1:0]        pending_q, pending_d;
  rule_e             rule_q, rule_d;
  logic              err_q, err_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] cont_q, cont_d;
  logic              out_valid_q, out_valid_d;
  logic              verdict_q, verdict_d;
  logic              take, rule_hit, verdict;

  // Stall only a final byte while an earlier verdict is still waiting
  assign cls_ready_o = !(cls_i.last && out_valid_q && !out_ready_i);
  assign take        = cls_valid_i && cls_ready_o;
  assign out_valid_o = out_valid_q;
  assign is_valid_o  = verdict_q;

  always_comb begin
    rule_hit = 1'b0;
    case (rule_q)
      RULE_E0: rule_hit = cls_i.viol_e0;
      RULE_ED: rule_hit = cls_i.viol_ed;
      RULE_F0: rule_hit = cls_i.viol_f0;
      default: rule_hit = 1'b0;
    endcase
  end

  // Update parse state and saturating counters for one byte
  always_comb begin
    pending_d   = pending_q;
    rule_d      = rule_q;
    err_d       = err_q;
    total_d     = (total_q >= CountW'(MaxMessageBytes)) ? total_q : total_q + 1'b1;
    cont_d      = cont_q;
    out_valid_d = out_valid_q && !out_ready_i;
    verdict_d   = verdict_q;
    if (cls_i.is_cont && cont_q < CountW'(MaxMessageBytes)) begin
      cont_d = cont_q + 1'b1;
    end
    if (err_q) begin
      // Only count after an error
    end else if (pending_q != '0) begin
      if (!cls_i.is_cont || rule_hit) begin
        err_d     = 1'b1;
        pending_d = '0;
        rule_d    = RULE_NONE;
      end else begin
        rule_d    = RULE_NONE;
        pending_d = pending_q - 1'b1;
      end
    end else begin
      case (cls_i.kind)
        KIND_ASCII: ;
        KIND_LEAD2: begin
          pending_d = 2'd1;
          rule_d    = RULE_NONE;
        end
        KIND_LEAD3: begin
          pending_d = 2'd2;
          rule_d    = cls_i.rule;
        end
        KIND_LEAD4: begin
          pending_d = 2'd3;
          rule_d    = cls_i.rule;
        end
        default: begin
          err_d     = 1'b1;
          pending_d = '0;
          rule_d    = RULE_NONE;
        end
      endcase
    end
    verdict = !err_d && (pending_d == '0) && (cont_d <= (total_d >> 1));
    // Emit the verdict and clear for the next message on a final byte
    if (cls_i.last) begin
      out_valid_d = 1'b1;
      verdict_d   = verdict;
      pending_d   = '0;
      rule_d      = RULE_NONE;
      err_d       = 1'b0;
      total_d     = '0;
      cont_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      rule_q      <= RULE_NONE;
      err_q       <= 1'b0;
      total_q     <= '0;
      cont_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (take) begin
      pending_q   <= pending_d;
      rule_q      <= rule_d;
      err_q       <= err_d;
      total_q     <= total_d;
      cont_q      <= cont_d;
      out_valid_q <= out_valid_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the verdict payload until a new one arrives
  always_ff @(posedge clk_i) begin
    if (take) begin
      verdict_q <= verdict_d;
    end
  end

endmodule

### src/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator.
//
// Usage: message bytes enter on the s_axis channel, one byte per transaction,
// with s_axis_tlast high on the final byte of each message. For every final
// byte one verdict leaves on the m_axis channel: m_axis_tdata[0] is 1 when
// the message is well-formed UTF-8 (valid leads, complete sequences, no
// overlong E0/F0 forms, no surrogates, no leads above F4) and its
// continuation bytes number at most half its length; otherwise it is 0.
// Non-final bytes produce no output transaction.
// The front end classifies each byte combinationally and the queue registers
// it; the back end registers the verdict when it takes the final byte from the
// queue, and the verdict then appears on m_axis. Throughput: one byte per cycle,
// unless a final byte is held back by a pending verdict or the queue is full.
// A two-entry queue separates the classifier from the parser. When the
// receiver stalls, non-final bytes keep flowing; a final byte waits in the
// queue until the pending verdict is taken, and s_axis_tready drops once the
// queue fills. Reset empties the queue, drops any pending verdict and clears
// the parser for a new message.
module utf8_stream_validator import u8sv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] is_valid, [7:1] zero
);

  byte_class_t front_cls, back_cls;
  logic        front_valid, front_ready;
  logic        back_valid, back_ready;
  logic        is_valid;

  u8sv_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready),
    .cls_o       (front_cls)
  );

  u8sv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cls),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cls)
  );

  u8sv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (back_valid),
    .cls_ready_o (back_ready),
    .cls_i       (back_cls),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .is_valid_o  (is_valid)
  );

  assign m_axis_tdata = {7'd0, is_valid};

endmodule

### verif/utf8_stream_validator_tb.sv
// Self-checking testbench for the UTF-8 stream validator: directed table, random messages.
`timescale 1ns / 100ps

module utf8_stream_validator_tb import u8sv_pkg::*; ();

  // Row flags for the directed table
  localparam logic Last  = 1'b1;
  localparam logic More  = 1'b0;
  localparam logic Fixed = 1'b1;  // verdict written in the row
  localparam logic Pred  = 1'b0;  // verdict comes from the predictor
  localparam logic Good  = 1'b1;
  localparam logic Bad   = 1'b0;

  localparam logic [7:0] ContLo = 8'h80;
  localparam logic [7:0] ContHi = 8'hBF;

  localparam int RandomBytes = 1224;
  localparam int CycleLimit  = 2000000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fixed;
    logic       verdict;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  // Predictor state for the message in flight
  logic [1:0]        pend_q;
  rule_e             rule_q;
  logic              err_q;
  logic [CountW-1:0] total_q;
  logic [CountW-1:0] cont_q;

  logic       verdict_q[$];
  logic [7:0] msg_q[$];
  logic [7:0] want_byte;

  int n_err = 0;
  int n_valid = 0;
  int n_invalid = 0;
  int n_bytes = 0;
  int burst_left = 0;
  int cycle_cnt = 0;

  // Directed messages: ASCII extremes, stray continuation, bad leads, overlong
  // and surrogate forms, F4 with any continuation, cut-short sequences
  stim_row_t dir_rows [0:25] = '{
    '{8'h00, Last, Fixed, Good},
    '{8'h7F, Last, Fixed, Good},
    '{8'h80, Last, Fixed, Bad},
    '{8'hC0, More, Pred,  Bad},
    '{8'h80, Last, Fixed, Bad},
    '{8'hC1, Last, Fixed, Bad},
    '{8'hE0, More, Pred,  Bad},
    '{8'h9F, More, Pred,  Bad},
    '{8'hBF, Last, Fixed, Bad},
    '{8'hED, More, Pred,  Bad},
    '{8'hA0, More, Pred,  Bad},
    '{8'h80, Last, Fixed, Bad},
    '{8'hF0, More, Pred,  Bad},
    '{8'h8F, More, Pred,  Bad},
    '{8'h80, More, Pred,  Bad},
    '{8'h80, Last, Fixed, Bad},
    '{8'h41, More, Pred,  Bad},
    '{8'h41, More, Pred,  Bad},
    '{8'hF4, More, Pred,  Bad},
    '{8'hBF, More, Pred,  Bad},
    '{8'hBF, More, Pred,  Bad},
    '{8'hBF, Last, Pred,  Bad},
    '{8'hFF, Last, Fixed, Bad},
    '{8'hC2, More, Pred,  Bad},
    '{8'h41, Last, Fixed, Bad},
    '{8'hE1, Last, Fixed, Bad}
  };

  utf8_stream_validator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance the parser by one byte; return 1 with a verdict on a final byte
  function automatic logic take_byte(input logic [7:0] b, input logic lst,
                                     output logic verdict);
    logic is_cont;
    logic bad;
    is_cont = (b & MaskTop2) == PatCont;
    bad = 1'b0;
    verdict = 1'b0;
    if (32'(total_q) < MaxMessageBytes) total_q = total_q + 1'b1;
    if (is_cont && 32'(cont_q) < MaxMessageBytes) cont_q = cont_q + 1'b1;
    if (!err_q) begin
      if (pend_q != 2'd0) begin
        if (!is_cont) begin
          bad = 1'b1;
        end else if ((rule_q == RULE_E0 && (b & MaskTop3) == PatCont) ||
                     (rule_q == RULE_ED && (b & MaskTop3) == PatSurr) ||
                     (rule_q == RULE_F0 && (b & MaskTop4) == PatCont)) begin
          bad = 1'b1;
        end else begin
          rule_q = RULE_NONE;
          pend_q = pend_q - 2'd1;
        end
      end else if (b[7]) begin
        if ((b & MaskTop3) == PatLead2) begin
          if (b == ByteC0 || b == ByteC1) bad = 1'b1;
          else begin
            pend_q = 2'd1;
            rule_q = RULE_NONE;
          end
        end else if ((b & MaskTop4) == PatLead3) begin
          pend_q = 2'd2;
          rule_q = (b == ByteE0) ? RULE_E0 : (b == ByteED) ? RULE_ED : RULE_NONE;
        end else if ((b & MaskTop5) == PatLead4 && b <= ByteF4) begin
          pend_q = 2'd3;
          rule_q = (b == ByteF0) ? RULE_F0 : RULE_NONE;
        end else begin
          bad = 1'b1;
        end
      end
    end
    if (bad) begin
      err_q = 1'b1;
      pend_q = 2'd0;
      rule_q = RULE_NONE;
    end
    if (!lst) return 1'b0;
    verdict = !err_q && pend_q == 2'd0 && cont_q <= (total_q >> 1);
    pend_q = 2'd0;
    rule_q = RULE_NONE;
    err_q = 1'b0;
    total_q = '0;
    cont_q = '0;
    return 1'b1;
  endfunction

  // Send one byte with burst gaps; queue its verdict once the transaction completes
  task automatic push_byte(input logic [7:0] b, input logic lst, input logic fixed,
                           input logic fixed_val);
    logic has_v;
    logic v;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    has_v = take_byte(b, lst, v);
    if (has_v) verdict_q.insert(verdict_q.size(), fixed ? fixed_val : v);
    n_bytes++;
    @(negedge clk_i);
  endtask

  // Append one byte to the message under construction
  function automatic void append_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  // Append one well-formed character with random content
  task automatic add_char();
    logic [7:0] lead;
    case ($urandom_range(0, 9))
      6, 7: begin
        append_byte(8'($urandom_range(8'hC2, 8'hDF)));
        append_byte(8'($urandom_range(ContLo, ContHi)));
      end
      8: begin
        case ($urandom_range(0, 2))
          0: lead = ByteE0;
          1: lead = ByteED;
          default: lead = 8'($urandom_range(ByteE0, 8'hEF));
        endcase
        append_byte(lead);
        if (lead == ByteE0) append_byte(8'($urandom_range(PatSurr, ContHi)));
        else if (lead == ByteED) append_byte(8'($urandom_range(ContLo, 8'h9F)));
        else append_byte(8'($urandom_range(ContLo, ContHi)));
        append_byte(8'($urandom_range(ContLo, ContHi)));
      end
      9: begin
        lead = 8'($urandom_range(ByteF0, ByteF4));
        append_byte(lead);
        if (lead == ByteF0) append_byte(8'($urandom_range(8'h90, ContHi)));
        else append_byte(8'($urandom_range(ContLo, ContHi)));
        repeat (2) append_byte(8'($urandom_range(ContLo, ContHi)));
      end
      default: append_byte(8'($urandom_range(0, 8'h7F)));
    endcase
  endtask

  // Build a message: mostly well-formed, the rest corrupted or pure noise
  task automatic build_message();
    int n_chars;
    int idx;
    msg_q.delete();
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    repeat (n_chars) add_char();
    idx = $urandom_range(0, msg_q.size() - 1);
    case ($urandom_range(0, 7))
      0: msg_q[idx] = 8'($urandom_range(0, 255));
      1: if (msg_q.size() > 1) void'(msg_q.pop_back());
      2: msg_q.insert(idx, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // Receiver ready: modes of full speed, light stall, heavy stall and periodic stall
  int rcv_mode = 0;
  int rcv_left = 0;
  int rcv_phase = 0;
  always @(negedge clk_i) begin
    if (rcv_left == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_left = $urandom_range(16, 96);
    end
    rcv_left--;
    rcv_phase = (rcv_phase + 1) % 5;
    case (rcv_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rcv_phase != 0);
    endcase
  end

  // Check each verdict transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual %h", $time, m_tdata);
        n_err++;
      end else begin
        want_byte = {7'd0, verdict_q.pop_front()};
        if (m_tdata !== want_byte) begin
          $display("%0t: verdict mismatch, expected %h, actual %h", $time, want_byte,
                   m_tdata);
          n_err++;
        end
        if (want_byte[0]) n_valid++;
        else n_invalid++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int sent;
    pend_q = 2'd0;
    rule_q = RULE_NONE;
    err_q = 1'b0;
    total_q = '0;
    cont_q = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_rows[i])
      push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].fixed,
                dir_rows[i].verdict);

    // Random messages
    sent = 0;
    while (sent < RandomBytes) begin
      build_message();
      foreach (msg_q[i]) push_byte(msg_q[i], i == msg_q.size() - 1, Pred, Bad);
      sent += msg_q.size();
    end

    // Drain outstanding verdicts, then hold for stray output
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d valid and %0d invalid verdicts,", n_bytes,
             n_valid, n_invalid);
    $display("from edge-case messages and random messages under bursty input and stalls");
    if (n_err == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
